// File: hdl/mbwt_pkg.sv
// Package for the markup body word tokenizer.
// Holds character constants, result item layout and the word character test.
// No dependencies.
package mbwt_pkg;

   localparam int COUNT_BITS_DEFAULT = 24;
   localparam int QUEUE_DEPTH        = 4;

   localparam logic ITEM_CHAR = 1'b0;
   localparam logic ITEM_END  = 1'b1;

   localparam logic [7:0] CH_LT     = 8'h3C;  // '<'
   localparam logic [7:0] CH_GT     = 8'h3E;  // '>'
   localparam logic [7:0] CH_SLASH  = 8'h2F;  // '/'
   localparam logic [7:0] CH_B      = 8'h42;
   localparam logic [7:0] CH_O      = 8'h4F;
   localparam logic [7:0] CH_D      = 8'h44;
   localparam logic [7:0] CH_Y      = 8'h59;
   localparam logic [7:0] CH_PERIOD = 8'h2E;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_BTICK  = 8'h60;

   typedef struct packed {
      logic        kind;
      logic [7:0]  ch;
      logic [23:0] doc;
      logic [23:0] pos;
      logic [31:0] total;
   } result_type;

   function automatic logic is_word_char(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h30 && c <= 8'h39) || c == CH_PERIOD || c == CH_COMMA ||
             c == CH_QUOTE || c == CH_BTICK;
   endfunction

endpackage

// File: hdl/markup_body_word_tokenizer.sv
// Markup body word tokenizer, top level.
// Results of an accepted request are registered in the result queue and leave from its head.
// Throughput: one request per cycle while the four-entry result queue has two free slots.
// Rate is set by the result queue drain: a request may yield two results, one leaves per cycle while rsp_stall is low.
// Reset (synchronous, active high) clears tag state, held character, counters and the queue.
// Depends on mbwt_pkg.
module markup_body_word_tokenizer
   import mbwt_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_item_kind,
   output logic [7:0]  rsp_word_char,
   output logic [23:0] rsp_doc_number,
   output logic [23:0] rsp_word_position,
   output logic [31:0] rsp_words_total
);

   localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int QIDX_BITS = $clog2(QUEUE_DEPTH);

   // ---------------- tokenizer state ----------------
   logic                  tag_ff, tag_in;           // inside a tag
   logic                  closing_ff, closing_in;   // '/' seen in current tag
   logic [3:0][7:0]       prefix_ff, prefix_in;     // first four tag characters
   logic [2:0]            tlen_ff, tlen_in;         // captured count, stops at 4
   logic                  held_v_ff, held_v_in;     // one-character delay line
   logic [7:0]            held_c_ff, held_c_in;
   logic                  started_ff, started_in;   // some char of word already sent
   logic [COUNT_BITS-1:0] doc_ff, doc_in;
   logic [COUNT_BITS-1:0] pos_ff, pos_in;
   logic [31:0]           words_ff, words_in;

   // ---------------- result queue ----------------
   // Head is always entry 0; entries shift down on a pop.
   result_type [QUEUE_DEPTH-1:0] q_ff, q_in;
   logic [QCNT_BITS-1:0]         qcnt_ff, qcnt_in;

   logic       accept, pop;
   logic [1:0] n_res;
   result_type res0, res1;

   logic [7:0]  c;
   logic        body;
   logic        emit_held, nonempty;
   logic [31:0] words_inc;
   logic [31:0] doc_wide, pos_wide;
   logic [3:0][7:0] prefix_cut;
   logic [QCNT_BITS-1:0] cnt_after_pop;
   logic [QIDX_BITS-1:0] widx;

   // stall when fewer than two free slots; never looks at req_valid
   assign req_stall = (qcnt_ff > QCNT_BITS'(QUEUE_DEPTH - 2));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (qcnt_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;

   assign rsp_item_kind     = q_ff[0].kind;
   assign rsp_word_char     = q_ff[0].ch;
   assign rsp_doc_number    = q_ff[0].doc;
   assign rsp_word_position = q_ff[0].pos;
   assign rsp_words_total   = q_ff[0].total;

   assign c    = req_in_byte;
   assign body = (prefix_ff[0] == CH_B) && (prefix_ff[1] == CH_O) &&
                 (prefix_ff[2] == CH_D) && (prefix_ff[3] == CH_Y);

   // held char is dropped when it is a trailing '.' or ','
   assign emit_held = held_v_ff && (held_c_ff != CH_PERIOD) && (held_c_ff != CH_COMMA);
   assign nonempty  = started_ff || emit_held;
   assign words_inc = (&words_ff) ? words_ff : words_ff + 32'd1;
   assign doc_wide  = 32'(doc_ff);
   assign pos_wide  = 32'(pos_ff);

   // ---------------- per-byte step ----------------
   always_comb begin
      tag_in     = tag_ff;
      closing_in = closing_ff;
      prefix_in  = prefix_ff;
      prefix_cut = prefix_ff;
      tlen_in    = tlen_ff;
      held_v_in  = held_v_ff;
      held_c_in  = held_c_ff;
      started_in = started_ff;
      doc_in     = doc_ff;
      pos_in     = pos_ff;
      words_in   = words_ff;
      n_res      = 2'd0;
      res0       = '0;
      res1       = '0;

      if (accept) begin
         if (tag_ff) begin
            if (c == CH_SLASH) begin
               closing_in = 1'b1;
            end else if (c == CH_GT) begin
               tag_in = 1'b0;
               // short tag: clear the slot after the last capture
               if (tlen_ff < 3'd4) begin
                  prefix_cut[tlen_ff[1:0]] = '0;
               end
               prefix_in = prefix_cut;
               if (closing_ff && prefix_cut[0] == CH_B && prefix_cut[1] == CH_O &&
                   prefix_cut[2] == CH_D && prefix_cut[3] == CH_Y) begin
                  doc_in = (&doc_ff) ? doc_ff : doc_ff + COUNT_BITS'(1);
                  pos_in = '0;
               end
               tlen_in = 3'd0;
            end else if (tlen_ff < 3'd4) begin
               prefix_in[tlen_ff[1:0]] = c;
               tlen_in = tlen_ff + 3'd1;
            end
         end else if (c == CH_LT || (body && !is_word_char(c))) begin
            // word end: flush held char, then end item
            if (c == CH_LT) begin
               tag_in     = 1'b1;
               closing_in = 1'b0;
            end
            if (emit_held) begin
               res0.kind = ITEM_CHAR;
               res0.ch   = held_c_ff;
            end
            if (nonempty) begin
               words_in = words_inc;
               pos_in   = (&pos_ff) ? pos_ff : pos_ff + COUNT_BITS'(1);
               if (emit_held) begin
                  res1.kind  = ITEM_END;
                  res1.doc   = doc_wide[23:0];
                  res1.pos   = pos_wide[23:0];
                  res1.total = words_inc;
                  n_res      = 2'd2;
               end else begin
                  res0.kind  = ITEM_END;
                  res0.doc   = doc_wide[23:0];
                  res0.pos   = pos_wide[23:0];
                  res0.total = words_inc;
                  n_res      = 2'd1;
               end
            end
            held_v_in  = 1'b0;
            held_c_in  = '0;
            started_in = 1'b0;
         end else if (body) begin
            if (held_v_ff) begin
               res0.kind  = ITEM_CHAR;
               res0.ch    = held_c_ff;
               n_res      = 2'd1;
               started_in = 1'b1;
            end
            held_c_in = c;
            held_v_in = 1'b1;
         end
      end
   end

   // ---------------- queue update ----------------
   always_comb begin
      q_in          = q_ff;
      cnt_after_pop = qcnt_ff;
      if (pop) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            q_in[i] = q_ff[i+1];
         end
         cnt_after_pop = qcnt_ff - QCNT_BITS'(1);
      end
      widx = cnt_after_pop[QIDX_BITS-1:0];
      if (n_res != 2'd0) begin
         q_in[widx] = res0;
      end
      if (n_res == 2'd2) begin
         q_in[widx + QIDX_BITS'(1)] = res1;
      end
      qcnt_in = cnt_after_pop + QCNT_BITS'(n_res);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff     <= 1'b0;
         closing_ff <= 1'b0;
         prefix_ff  <= '0;
         tlen_ff    <= '0;
         held_v_ff  <= 1'b0;
         held_c_ff  <= '0;
         started_ff <= 1'b0;
         doc_ff     <= '0;
         pos_ff     <= '0;
         words_ff   <= '0;
         qcnt_ff    <= '0;
      end else begin
         tag_ff     <= tag_in;
         closing_ff <= closing_in;
         prefix_ff  <= prefix_in;
         tlen_ff    <= tlen_in;
         held_v_ff  <= held_v_in;
         held_c_ff  <= held_c_in;
         started_ff <= started_in;
         doc_ff     <= doc_in;
         pos_ff     <= pos_in;
         words_ff   <= words_in;
         qcnt_ff    <= qcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   // ---------------- checks ----------------
   a_qcnt_bound: assert property (@(posedge clock) disable iff (reset)
      qcnt_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_end_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item_kind == ITEM_END) |-> (rsp_words_total != 32'd0))
      else $error("end item with zero word total");

   a_char_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item_kind == ITEM_CHAR) |->
         (rsp_doc_number == '0 && rsp_word_position == '0 && rsp_words_total == '0))
      else $error("character item carries counter fields");

   a_tag_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && tag_ff) |=> (qcnt_ff <= $past(qcnt_ff)))
      else $error("tag byte produced a result");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for markup_body_word_tokenizer: byte stream in, word items out.
// Holds a token scoreboard class with its own tokenizer model; depends on mbwt_pkg.
import mbwt_pkg::*;

class token_scoreboard;
   // model copy of the tokenizer state
   bit          in_tag;
   bit          closing;
   logic [7:0]  prefix [4];
   int unsigned prefix_len;
   bit          held_valid;
   logic [7:0]  held_char;
   bit          started;
   logic [23:0] doc_count;
   logic [23:0] pos_count;
   logic [31:0] word_count;

   result_type  expected_tokens [$];
   int unsigned mismatches;

   function new();
      in_tag     = 0;
      closing    = 0;
      foreach (prefix[i]) prefix[i] = 8'h00;
      prefix_len = 0;
      held_valid = 0;
      held_char  = 8'h00;
      started    = 0;
      doc_count  = '0;
      pos_count  = '0;
      word_count = '0;
      mismatches = 0;
   endfunction

   function void add_expected(result_type r);
      expected_tokens = {expected_tokens, r};
   endfunction

   function bit body_prefix();
      return prefix[0] == CH_B && prefix[1] == CH_O && prefix[2] == CH_D && prefix[3] == CH_Y;
   endfunction

   function bit word_byte(logic [7:0] c);
      if (c >= 8'h61 && c <= 8'h7A) return 1;   // a..z
      if (c >= 8'h41 && c <= 8'h5A) return 1;   // A..Z
      if (c >= 8'h30 && c <= 8'h39) return 1;   // 0..9
      return c == CH_PERIOD || c == CH_COMMA || c == CH_QUOTE || c == CH_BTICK;
   endfunction

   // flush held char (unless trailing '.' or ',') and emit the end item
   function void close_word();
      bit nonempty;
      nonempty = started;
      if (held_valid && held_char != CH_PERIOD && held_char != CH_COMMA) begin
         add_expected({ITEM_CHAR, held_char, 24'd0, 24'd0, 32'd0});
         nonempty = 1;
      end
      if (nonempty) begin
         if (word_count != '1) word_count = word_count + 32'd1;
         add_expected({ITEM_END, 8'h00, doc_count, pos_count, word_count});
         if (pos_count != '1) pos_count = pos_count + 24'd1;
      end
      held_valid = 0;
      held_char  = 8'h00;
      started    = 0;
   endfunction

   function void accept_byte(logic [7:0] c);
      if (in_tag) begin
         if (c == CH_SLASH) begin
            closing = 1;
         end else if (c == CH_GT) begin
            in_tag = 0;
            if (prefix_len < 4) prefix[prefix_len] = 8'h00;
            if (closing && body_prefix()) begin
               if (doc_count != '1) doc_count = doc_count + 24'd1;
               pos_count = '0;
            end
            prefix_len = 0;
         end else if (prefix_len < 4) begin
            prefix[prefix_len] = c;
            prefix_len++;
         end
      end else if (c == CH_LT) begin
         close_word();
         in_tag  = 1;
         closing = 0;
      end else if (body_prefix()) begin
         if (word_byte(c)) begin
            if (held_valid) begin
               add_expected({ITEM_CHAR, held_char, 24'd0, 24'd0, 32'd0});
               started = 1;
            end
            held_char  = c;
            held_valid = 1;
         end else begin
            close_word();
         end
      end
   endfunction

   task report_mismatch(string what);
      $display("MISMATCH: %s", what);
      mismatches++;
   endtask

   task check_item(result_type got);
      result_type want;
      if (expected_tokens.size() == 0) begin
         report_mismatch($sformatf("unexpected item kind=%0d char=%h", got.kind, got.ch));
      end else begin
         want = expected_tokens.pop_front();
         if (got.kind !== want.kind)
            report_mismatch($sformatf("item_kind %0d, want %0d", got.kind, want.kind));
         if (got.ch !== want.ch)
            report_mismatch($sformatf("word_char %h, want %h", got.ch, want.ch));
         if (got.doc !== want.doc)
            report_mismatch($sformatf("doc_number %0d, want %0d", got.doc, want.doc));
         if (got.pos !== want.pos)
            report_mismatch($sformatf("word_position %0d, want %0d", got.pos, want.pos));
         if (got.total !== want.total)
            report_mismatch($sformatf("words_total %0d, want %0d", got.total, want.total));
      end
   endtask
endclass

module tb_top;
   localparam int RANDOM_BYTES = 1350;
   localparam int LONG_HOLD    = 120;      // receiver hold-off, cycles

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_SEMI  = 8'h3B;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_item_kind;
   logic [7:0]  rsp_word_char;
   logic [23:0] rsp_doc_number;
   logic [23:0] rsp_word_position;
   logic [31:0] rsp_words_total;

   token_scoreboard tokens;
   logic [7:0]      text_bytes [$];   // bytes waiting to be sent
   int              phase = 0;        // 0: slow receiver, 1: slow sender, 2: no idling
   int              random_sent = 0;
   int              hold_left = 0;
   bit              long_hold_done = 0;

   markup_body_word_tokenizer DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_item_kind     (rsp_item_kind),
      .rsp_word_char     (rsp_word_char),
      .rsp_doc_number    (rsp_doc_number),
      .rsp_word_position (rsp_word_position),
      .rsp_words_total   (rsp_words_total)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop in case the handshake hangs; a correct run needs well under a tenth of this.
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Receiver: check the item accepted at this edge, then pick the next stall.
   // Values read here are pre-edge, the block updates after the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tokens.check_item({rsp_item_kind, rsp_word_char, rsp_doc_number,
                            rsp_word_position, rsp_words_total});
      // one long hold-off at the start of the no-idle phase: the
      // four-entry result queue fills and the block must stall the sender
      if (phase == 2 && !long_hold_done) begin
         hold_left      = LONG_HOLD;
         long_hold_done = 1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (phase)
            0:       rsp_stall <= ($urandom_range(0, 99) < 75);
            1:       rsp_stall <= ($urandom_range(0, 99) < 31);
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   // Offer one request; valid and payload hold while stalled.
   // Called right after a rising edge, so every NBA here lands once per step.
   task automatic send_request(input logic [7:0] b);
      int idle_pct;
      idle_pct = (phase == 0) ? 31 : (phase == 1) ? 75 : 0;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tokens.accept_byte(b);
   endtask

   function automatic void queue_byte(input logic [7:0] b);
      text_bytes = {text_bytes, b};
   endfunction

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
   endtask

   function automatic logic [7:0] pick_word_char();
      case ($urandom_range(0, 9))
         0, 1, 2: return 8'(8'h61 + $urandom_range(0, 25));   // lower case
         3, 4:    return 8'(8'h41 + $urandom_range(0, 25));   // upper case
         5, 6:    return 8'(8'h30 + $urandom_range(0, 9));    // digit
         7:       return CH_PERIOD;
         8:       return CH_COMMA;
         default: return $urandom_range(0, 1) ? CH_QUOTE : CH_BTICK;
      endcase
   endfunction

   function automatic logic [7:0] pick_separator();
      case ($urandom_range(0, 8))
         0, 1:    return CH_SPACE;
         2:       return CH_NL;
         3:       return CH_BANG;
         4:       return CH_SEMI;
         5:       return CH_GT;                          // stray '>' outside a tag
         6:       return CH_SLASH;
         7:       return 8'($urandom_range(8'h80, 8'hFF));
         default: return 8'($urandom_range(8'h00, 8'h1F));
      endcase
   endfunction

   // word of 1..7 chars, sometimes with a trailing '.' or ',' to strip
   task automatic push_word();
      int n;
      n = $urandom_range(1, 7);
      repeat (n) queue_byte(pick_word_char());
      if ($urandom_range(0, 4) == 0)
         queue_byte($urandom_range(0, 1) ? CH_PERIOD : CH_COMMA);
   endtask

   // One random chunk: mostly well-formed body documents, then other
   // tags, raw noise and malformed tags.
   task automatic build_chunk();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         case ($urandom_range(0, 2))
            0:       push_text("<BODY>");
            1:       push_text("<BODY TYPE=x>");   // long tag, still BODY
            default: push_text("<BODYTEXT>");
         endcase
         n = $urandom_range(1, 10);
         repeat (n) begin
            push_word();
            if ($urandom_range(0, 5) != 0) queue_byte(pick_separator());
         end
         case ($urandom_range(0, 3))
            0, 1:    push_text("</BODY>");
            2:       push_text("<BODY/>");         // slash anywhere closes
            default: push_text("</BODYX>");
         endcase
      end else if (pick < 80) begin
         case ($urandom_range(0, 6))
            0:       push_text("<TITLE>");
            1:       push_text("<B>");             // short tag clears stale prefix
            2:       push_text("<BOD>");
            3:       push_text("<<BODY>");         // '<' captured inside the tag
            4:       push_text("</TEXT>");
            5:       push_text("<>");
            default: push_text("<//>");
         endcase
         n = $urandom_range(1, 4);
         repeat (n) begin
            push_word();
            queue_byte(pick_separator());
         end
      end else if (pick < 90) begin
         n = $urandom_range(1, 6);
         repeat (n) queue_byte(8'($urandom_range(0, 255)));
      end else begin
         queue_byte(CH_LT);
         n = $urandom_range(0, 6);
         repeat (n) queue_byte(8'($urandom_range(0, 255)));
         queue_byte(CH_GT);
      end
   endtask

   initial begin
      tokens = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: byte extremes, body open, trailing period stripped,
      // single-char word cut by '<' (char plus end item), closing BODY
      // advances the document, trailing comma, '<' inside a short tag.
      queue_byte(8'hFF);
      push_text("<BODYX>a. z</BODY>`9,<<>");
      queue_byte(8'h00);
      while (text_bytes.size() != 0) send_request(text_bytes.pop_front());

      // Random stream, idling pattern switching by thirds.
      while (random_sent < RANDOM_BYTES) begin
         build_chunk();
         while (text_bytes.size() != 0) begin
            phase = (random_sent * 3) / RANDOM_BYTES;
            if (phase > 2) phase = 2;
            send_request(text_bytes.pop_front());
            random_sent++;
         end
      end
      req_valid <= 1'b0;

      // drain, then keep watching for anything spurious
      while (tokens.expected_tokens.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tokens.expected_tokens.size() != 0)
         tokens.report_mismatch("items still expected at end of run");

      if (tokens.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
